/* rtl/core/array_linked_ring_store_core_defines.svh */
// Assertion macros shared by the checker.
`ifndef ARRAY_LINKED_RING_STORE_CORE_DEFINES_SVH
`define ARRAY_LINKED_RING_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ALRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alrs check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ALRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alrs check failed");

`endif

/* rtl/core/alrs_pkg.sv */
package alrs_pkg;

	localparam int FUNC_W  = 3;
	localparam int VAL_W   = 8;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_RANGE_DEF = 256;

	localparam logic [FUNC_W-1:0] F_INS_AFTER  = 3'd0;
	localparam logic [FUNC_W-1:0] F_INS_BEFORE = 3'd1;
	localparam logic [FUNC_W-1:0] F_REMOVE     = 3'd2;
	localparam logic [FUNC_W-1:0] F_NEXT       = 3'd3;
	localparam logic [FUNC_W-1:0] F_PREV       = 3'd4;
	localparam logic [FUNC_W-1:0] F_FIRST      = 3'd5;

	localparam logic [STAT_W-1:0] S_OK       = 2'd0;
	localparam logic [STAT_W-1:0] S_NONEMPTY = 2'd1;
	localparam logic [STAT_W-1:0] S_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] S_ABSENT   = 2'd3;

	typedef logic [COUNT_W-1:0] count_out_t;

	typedef struct packed {
		logic [VAL_W-1:0]  answer;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

/* rtl/core/array_linked_ring_store_core.sv */
// Ring store of distinct values held as a circular doubly linked list in dense slots.
// One transaction in gives exactly one transaction out (answer, status, count after
// the operation). Transactions are handled one at a time by a sequencer that does
// read-modify-write passes over two RAMs with registered reads: a slot RAM holding
// {value, next, prev} per slot and a value-to-slot map. How long a transaction takes
// is set by the slot RAM's single port pair: every link update is a read then a write
// to that RAM. After reset the map RAM is swept to zero, one entry a cycle, and
// in_stall stays high until all 2^VW entries (256 with the default value range) are
// clear. A value counts as held only when its map entry points at a live slot that
// holds that same value. A finished result sits in an output register, and a new
// transaction is taken while it waits.
module array_linked_ring_store_core import alrs_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [VAL_W-1:0]  item_value,
	input  logic [VAL_W-1:0]  anchor_value,
	input  logic              anchor_none,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VAL_W-1:0]  answer_value,
	output logic [STAT_W-1:0] status,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
	localparam int WW = VAL_W + 2 * SW;

	logic          slot_rd_en, slot_wr_en, map_rd_en, map_wr_en;
	logic [SW-1:0] slot_rd_addr, slot_wr_addr, map_rd_data, map_wr_data;
	logic [WW-1:0] slot_rd_data, slot_wr_data;
	logic [VW-1:0] map_rd_addr, map_wr_addr;
	logic          res_valid, out_free;
	res_t          res;
	logic [CW-1:0] count;

	// output register state
	logic          out_valid_q;
	res_t          out_res_q;
	count_out_t    out_count_q;

	// slot RAM rounded up to a power of two so any link code addresses it
	alrs_ram #(.WIDTH(WW), .DEPTH(1 << SW)) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.rd_en   (slot_rd_en),
		.rd_addr (slot_rd_addr),
		.rd_data (slot_rd_data)
	);

	alrs_ram #(.WIDTH(SW), .DEPTH(1 << VW)) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data),
		.rd_en   (map_rd_en),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data)
	);

	alrs_seq #(.CAPACITY(CAPACITY), .VALUE_RANGE(VALUE_RANGE)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.item_value   (item_value),
		.anchor_value (anchor_value),
		.anchor_none  (anchor_none),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res),
		.count        (count),
		.slot_rd_en   (slot_rd_en),
		.slot_rd_addr (slot_rd_addr),
		.slot_rd_data (slot_rd_data),
		.slot_wr_en   (slot_wr_en),
		.slot_wr_addr (slot_wr_addr),
		.slot_wr_data (slot_wr_data),
		.map_rd_en    (map_rd_en),
		.map_rd_addr  (map_rd_addr),
		.map_rd_data  (map_rd_data),
		.map_wr_en    (map_wr_en),
		.map_wr_addr  (map_wr_addr),
		.map_wr_data  (map_wr_data)
	);

	// output register frees up in the same cycle its transaction is taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q   <= res;
			out_count_q <= count_out_t'(count);
		end
	end

	assign out_valid    = out_valid_q;
	assign answer_value = out_res_q.answer;
	assign status       = out_res_q.status;
	assign entry_count  = out_count_q;

endmodule

/* rtl/core/alrs_ram.sv */
module alrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/alrs_seq.sv */
module alrs_seq import alrs_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_RANGE = VALUE_RANGE_DEF,
	localparam int SW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1,
	localparam int WW = VAL_W + 2 * SW
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [VAL_W-1:0]  item_value,
	input  logic [VAL_W-1:0]  anchor_value,
	input  logic              anchor_none,
	// result side
	input  logic              out_free,
	output logic              res_valid,
	output res_t              res,
	output logic [CW-1:0]     count,
	// slot memory {value, next, prev}
	output logic              slot_rd_en,
	output logic [SW-1:0]     slot_rd_addr,
	input  logic [WW-1:0]     slot_rd_data,
	output logic              slot_wr_en,
	output logic [SW-1:0]     slot_wr_addr,
	output logic [WW-1:0]     slot_wr_data,
	// value-to-slot map
	output logic              map_rd_en,
	output logic [VW-1:0]     map_rd_addr,
	input  logic [SW-1:0]     map_rd_data,
	output logic              map_wr_en,
	output logic [VW-1:0]     map_wr_addr,
	output logic [SW-1:0]     map_wr_data
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_LOOK = 5'd1;
	localparam logic [4:0] ST_KEY1 = 5'd2;
	localparam logic [4:0] ST_KEY2 = 5'd3;
	localparam logic [4:0] ST_ANS  = 5'd4;
	localparam logic [4:0] ST_VCHK = 5'd5;
	localparam logic [4:0] ST_IPW  = 5'd6;
	localparam logic [4:0] ST_INW  = 5'd7;
	localparam logic [4:0] ST_R1W  = 5'd8;
	localparam logic [4:0] ST_R2R  = 5'd9;
	localparam logic [4:0] ST_R2W  = 5'd10;
	localparam logic [4:0] ST_R3R  = 5'd11;
	localparam logic [4:0] ST_R3W  = 5'd12;
	localparam logic [4:0] ST_R4W  = 5'd13;
	localparam logic [4:0] ST_R5R  = 5'd14;
	localparam logic [4:0] ST_R5W  = 5'd15;
	localparam logic [4:0] ST_R6   = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;
	localparam logic [4:0] ST_CLR  = 5'd18;

	logic [4:0]        state_q, state_d;
	logic [VW-1:0]     clr_q;
	logic [FUNC_W-1:0] func_q;
	logic [VAL_W-1:0]  item_q, anchor_q;
	logic              none_q;
	logic [CW-1:0]     count_q, cnt_d;
	logic              cnt_ld;
	logic [SW-1:0]     a_slot_q, v_slot_q, p_q, n_q, lp_q, ln_q;
	logic [VAL_W-1:0]  lval_q;
	logic [WW-1:0]     key_word_q;
	res_t              res_q;

	logic              fin;
	res_t              fin_res;
	logic              is_ins, is_after;
	logic [VAL_W-1:0]  key;
	logic              key_in_range, item_in_range, key_held, v_held;
	logic [VAL_W-1:0]  rd_val;
	logic [SW-1:0]     rd_next, rd_prev, kw_next, kw_prev;
	logic [SW-1:0]     new_slot, ins_p, ins_n, lp_fix, ln_fix;

	assign rd_val  = slot_rd_data[WW-1 -: VAL_W];
	assign rd_next = slot_rd_data[2*SW-1:SW];
	assign rd_prev = slot_rd_data[SW-1:0];
	assign kw_next = key_word_q[2*SW-1:SW];
	assign kw_prev = key_word_q[SW-1:0];

	assign is_ins   = (func_q == F_INS_AFTER) || (func_q == F_INS_BEFORE);
	assign is_after = (func_q == F_INS_AFTER);
	assign key      = is_ins ? anchor_q : item_q;

	assign key_in_range  = 32'(key) < 32'(VALUE_RANGE);
	assign item_in_range = 32'(item_q) < 32'(VALUE_RANGE);
	// held: map entry points at a live slot that really holds the value
	assign key_held = (CW'(a_slot_q) < count_q) && (rd_val == key) && key_in_range;
	assign v_held   = (CW'(v_slot_q) < count_q) && (rd_val == item_q);

	assign new_slot = count_q[SW-1:0];
	assign ins_p    = is_after ? a_slot_q : kw_prev;
	assign ins_n    = is_after ? kw_next : a_slot_q;
	// last slot is count_q after the decrement
	assign lp_fix   = (rd_prev == count_q[SW-1:0]) ? a_slot_q : rd_prev;
	assign ln_fix   = (rd_next == count_q[SW-1:0]) ? a_slot_q : rd_next;

	assign in_stall = (state_q != ST_IDLE);
	assign res      = res_q;
	assign count    = count_q;

	always_comb begin
		state_d      = state_q;
		fin          = 1'b0;
		fin_res      = '{answer: '0, status: S_OK};
		cnt_ld       = 1'b0;
		cnt_d        = count_q;
		res_valid    = 1'b0;
		slot_rd_en   = 1'b0;
		slot_rd_addr = '0;
		slot_wr_en   = 1'b0;
		slot_wr_addr = '0;
		slot_wr_data = '0;
		map_rd_en    = 1'b0;
		map_rd_addr  = '0;
		map_wr_en    = 1'b0;
		map_wr_addr  = '0;
		map_wr_data  = '0;
		unique case (state_q)
			ST_CLR: begin
				// sweep the map to zero after reset
				map_wr_en   = 1'b1;
				map_wr_addr = clr_q;
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				case (func_q) inside
					F_INS_AFTER, F_INS_BEFORE: begin
						if (none_q) begin
							fin = 1'b1;
							if (count_q != '0) begin
								fin_res.status = S_NONEMPTY;
							end else if (!item_in_range) begin
								fin_res.status = S_ABSENT;
							end else begin
								slot_wr_en   = 1'b1;
								slot_wr_data = {item_q, {SW{1'b0}}, {SW{1'b0}}};
								map_wr_en    = 1'b1;
								map_wr_addr  = VW'(item_q);
								cnt_ld       = 1'b1;
								cnt_d        = CW'(1);
							end
						end else begin
							map_rd_en   = 1'b1;
							map_rd_addr = VW'(anchor_q);
							state_d     = ST_KEY1;
						end
					end
					F_REMOVE, F_NEXT, F_PREV: begin
						map_rd_en   = 1'b1;
						map_rd_addr = VW'(item_q);
						state_d     = ST_KEY1;
					end
					F_FIRST: begin
						slot_rd_en = 1'b1;
						state_d    = ST_ANS;
					end
					default: fin = 1'b1;
				endcase
			end
			ST_KEY1: begin
				slot_rd_en   = 1'b1;
				slot_rd_addr = map_rd_data;
				map_rd_en    = is_ins;
				map_rd_addr  = VW'(item_q);
				state_d      = ST_KEY2;
			end
			ST_KEY2: begin
				case (func_q) inside
					F_INS_AFTER, F_INS_BEFORE: begin
						if (!key_held || !item_in_range) begin
							fin            = 1'b1;
							fin_res.status = S_ABSENT;
						end else if (count_q >= CW'(CAPACITY)) begin
							fin            = 1'b1;
							fin_res.status = S_FULL;
						end else begin
							slot_rd_en   = 1'b1;
							slot_rd_addr = map_rd_data;
							state_d      = ST_VCHK;
						end
					end
					F_REMOVE: begin
						if (!key_held) begin
							fin            = 1'b1;
							fin_res.status = S_ABSENT;
						end else if (count_q <= CW'(1)) begin
							fin    = 1'b1;
							cnt_ld = 1'b1;
							cnt_d  = '0;
						end else begin
							slot_rd_en   = 1'b1;
							slot_rd_addr = rd_prev;
							state_d      = ST_R1W;
						end
					end
					F_NEXT, F_PREV: begin
						if (!key_held) begin
							fin            = 1'b1;
							fin_res.status = S_ABSENT;
						end else begin
							slot_rd_en   = 1'b1;
							slot_rd_addr = (func_q == F_NEXT) ? rd_next : rd_prev;
							state_d      = ST_ANS;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_ANS: begin
				fin = 1'b1;
				if ((func_q == F_FIRST) && (count_q == '0)) begin
					fin_res.status = S_ABSENT;
				end else begin
					fin_res.answer = rd_val;
				end
			end
			ST_VCHK: begin
				if (v_held) begin
					fin = 1'b1;
				end else begin
					slot_wr_en   = 1'b1;
					slot_wr_addr = new_slot;
					slot_wr_data = {item_q, ins_n, ins_p};
					map_wr_en    = 1'b1;
					map_wr_addr  = VW'(item_q);
					map_wr_data  = new_slot;
					slot_rd_en   = 1'b1;
					slot_rd_addr = ins_p;
					state_d      = ST_IPW;
				end
			end
			ST_IPW: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = p_q;
				slot_wr_data = {rd_val, new_slot, (p_q == n_q) ? new_slot : rd_prev};
				if (p_q == n_q) begin
					fin    = 1'b1;
					cnt_ld = 1'b1;
					cnt_d  = count_q + CW'(1);
				end else begin
					slot_rd_en   = 1'b1;
					slot_rd_addr = n_q;
					state_d      = ST_INW;
				end
			end
			ST_INW: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = n_q;
				slot_wr_data = {rd_val, rd_next, new_slot};
				fin          = 1'b1;
				cnt_ld       = 1'b1;
				cnt_d        = count_q + CW'(1);
			end
			ST_R1W: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = p_q;
				slot_wr_data = {rd_val, n_q, rd_prev};
				state_d      = ST_R2R;
			end
			ST_R2R: begin
				slot_rd_en   = 1'b1;
				slot_rd_addr = n_q;
				state_d      = ST_R2W;
			end
			ST_R2W: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = n_q;
				slot_wr_data = {rd_val, rd_next, p_q};
				cnt_ld       = 1'b1;
				cnt_d        = count_q - CW'(1);
				if (CW'(a_slot_q) == cnt_d) begin
					fin = 1'b1;
				end else begin
					state_d = ST_R3R;
				end
			end
			ST_R3R: begin
				slot_rd_en   = 1'b1;
				slot_rd_addr = count_q[SW-1:0];
				state_d      = ST_R3W;
			end
			ST_R3W: begin
				map_wr_en    = 1'b1;
				map_wr_addr  = VW'(rd_val);
				map_wr_data  = a_slot_q;
				slot_rd_en   = 1'b1;
				slot_rd_addr = lp_fix;
				state_d      = ST_R4W;
			end
			ST_R4W: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = lp_q;
				slot_wr_data = {rd_val, a_slot_q, rd_prev};
				state_d      = ST_R5R;
			end
			ST_R5R: begin
				slot_rd_en   = 1'b1;
				slot_rd_addr = ln_q;
				state_d      = ST_R5W;
			end
			ST_R5W: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = ln_q;
				slot_wr_data = {rd_val, rd_next, a_slot_q};
				state_d      = ST_R6;
			end
			ST_R6: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = a_slot_q;
				slot_wr_data = {lval_q, ln_q, lp_q};
				fin          = 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) state_d = ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + VW'(1);
			if (cnt_ld) count_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			func_q   <= func;
			item_q   <= item_value;
			anchor_q <= anchor_value;
			none_q   <= anchor_none;
		end
		if (state_q == ST_KEY1) a_slot_q <= map_rd_data;
		if (state_q == ST_KEY2) begin
			key_word_q <= slot_rd_data;
			v_slot_q   <= map_rd_data;
			p_q        <= rd_prev;
			n_q        <= rd_next;
		end
		if (state_q == ST_VCHK) begin
			p_q <= ins_p;
			n_q <= ins_n;
		end
		if (state_q == ST_R3W) begin
			lp_q   <= lp_fix;
			ln_q   <= ln_fix;
			lval_q <= rd_val;
		end
		if (fin) res_q <= fin_res;
	end

endmodule

/* rtl/core/alrs_chk.sv */
`include "array_linked_ring_store_core_defines.svh"

module alrs_chk import alrs_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [VAL_W-1:0]   answer_value,
	input logic [STAT_W-1:0]  status,
	input logic [COUNT_W-1:0] entry_count
);

	// one transaction at a time: taking one closes the input
	`ALRS_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// a failed transaction never carries an answer
	`ALRS_ASSERT_NOW(a_fail_no_answer, out_valid && (status != S_OK), answer_value == '0)
	// count never exceeds the store size
	`ALRS_ASSERT_NOW(a_count_bound, out_valid, 32'(entry_count) <= 32'(CAPACITY))
	// a stalled result stays offered
	`ALRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind array_linked_ring_store_core alrs_chk #(.CAPACITY(CAPACITY)) u_alrs_chk (.*);

/* tb/tb_array_linked_ring_store_core.sv */
module tb_array_linked_ring_store_core;
	import alrs_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [FUNC_W-1:0] func = F_FIRST;
	logic [VAL_W-1:0] item_value = '0;
	logic [VAL_W-1:0] anchor_value = '0;
	logic anchor_none = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [VAL_W-1:0] answer_value;
	logic [STAT_W-1:0] status;
	logic [COUNT_W-1:0] entry_count;

	array_linked_ring_store_core uut (.*);

	always #2 clk = ~clk;

	localparam int SLOTS = CAPACITY_DEF;
	localparam int VALUES = VALUE_RANGE_DEF;
	localparam int CYCLE_LIMIT = 400000;

	// spare function codes, ignored by the block
	localparam logic [FUNC_W-1:0] F_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] F_SPARE_B = 3'd7;

	// expected result of one transaction
	typedef struct packed {
		logic [VAL_W-1:0] answer;
		logic [STAT_W-1:0] stat;
		logic [COUNT_W-1:0] count;
	} ring_result_t;

	ring_result_t pending_results[$];

	// shadow copy of the ring
	int ring_next[SLOTS];
	int ring_prev[SLOTS];
	int ring_val[SLOTS];
	int ring_slot[VALUES];
	bit ring_held[VALUES];
	int ring_count;

	int send_idle_pct, recv_stall_pct;
	int errors, results_seen, items_sent, cycles;
	int cnt_by_status[4];

	function automatic logic [STAT_W-1:0] ring_insert(int v, int a, bit after, bit none);
		int p, n, s;
		if (none) begin
			if (ring_count > 0) return S_NONEMPTY;
			ring_next[0] = 0; ring_prev[0] = 0; ring_val[0] = v;
			ring_slot[v] = 0; ring_held[v] = 1; ring_count = 1;
			return S_OK;
		end
		if (!ring_held[a]) return S_ABSENT;
		if (ring_count >= SLOTS) return S_FULL;
		if (ring_held[v]) return S_OK;
		if (after) begin
			p = ring_slot[a]; n = ring_next[p];
		end else begin
			n = ring_slot[a]; p = ring_prev[n];
		end
		s = ring_count;
		ring_val[s] = v; ring_next[s] = n; ring_prev[s] = p;
		ring_next[p] = s; ring_prev[n] = s;
		ring_slot[v] = s; ring_held[v] = 1; ring_count = s + 1;
		return S_OK;
	endfunction

	function automatic logic [STAT_W-1:0] ring_remove(int v);
		int pos, p, n, last, lp, ln;
		if (!ring_held[v]) return S_ABSENT;
		pos = ring_slot[v];
		ring_held[v] = 0;
		if (ring_count <= 1) begin
			ring_count = 0;
			return S_OK;
		end
		p = ring_prev[pos]; n = ring_next[pos];
		ring_next[p] = n; ring_prev[n] = p;
		ring_count--;
		last = ring_count;
		// last slot fills the hole; its self links point at the hole
		if (pos != last) begin
			lp = ring_prev[last]; ln = ring_next[last];
			if (lp == last) lp = pos;
			if (ln == last) ln = pos;
			ring_val[pos] = ring_val[last];
			ring_slot[ring_val[last]] = pos;
			ring_next[lp] = pos; ring_prev[ln] = pos;
			ring_next[pos] = ln; ring_prev[pos] = lp;
		end
		return S_OK;
	endfunction

	function automatic ring_result_t ring_predict(logic [FUNC_W-1:0] f, int v, int a, bit none);
		ring_result_t r;
		r = '0;
		case (f)
			F_INS_AFTER:  r.stat = ring_insert(v, a, 1, none);
			F_INS_BEFORE: r.stat = ring_insert(v, a, 0, none);
			F_REMOVE:     r.stat = ring_remove(v);
			F_NEXT: begin
				if (ring_held[v]) r.answer = VAL_W'(ring_val[ring_next[ring_slot[v]]]);
				else r.stat = S_ABSENT;
			end
			F_PREV: begin
				if (ring_held[v]) r.answer = VAL_W'(ring_val[ring_prev[ring_slot[v]]]);
				else r.stat = S_ABSENT;
			end
			F_FIRST: begin
				if (ring_count > 0) r.answer = VAL_W'(ring_val[0]);
				else r.stat = S_ABSENT;
			end
			default: ;
		endcase
		r.count = COUNT_W'(ring_count);
		return r;
	endfunction

	// one transaction into the block; prediction made at acceptance
	task automatic send_op(logic [FUNC_W-1:0] f, int v, int a = 0, bit none = 0);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		item_value <= VAL_W'(v);
		anchor_value <= VAL_W'(a);
		anchor_none <= none;
		do @(posedge clk); while (in_stall);
		pending_results = {pending_results, ring_predict(f, v, a, none)};
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// receiver stall and result check
	always @(posedge clk) begin
		ring_result_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result ans=%0d st=%0d cnt=%0d",
						$time, answer_value, status, entry_count);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					cnt_by_status[status]++;
					if (answer_value !== exp_r.answer) begin
						$display("%0t: answer exp %0d got %0d", $time, exp_r.answer, answer_value);
						errors++;
					end
					if (status !== exp_r.stat) begin
						$display("%0t: status exp %0d got %0d", $time, exp_r.stat, status);
						errors++;
					end
					if (entry_count !== exp_r.count) begin
						$display("%0t: count exp %0d got %0d", $time, exp_r.count, entry_count);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_held();
		if (ring_count == 0) return $urandom_range(255);
		return ring_val[$urandom_range(ring_count - 1)];
	endfunction

	// directed: empty ring cases, start, both inserts, self links, spare codes, removes
	task automatic test_directed();
		send_op(F_FIRST, 0);
		send_op(F_NEXT, 255);
		send_op(F_REMOVE, 7);
		send_op(F_INS_AFTER, 5, 9);          // anchor on empty ring
		send_op(F_INS_AFTER, 0, 200, 1);     // start
		send_op(F_INS_BEFORE, 1, 0, 1);      // start on non-empty
		send_op(F_NEXT, 0);                  // self link
		send_op(F_INS_AFTER, 255, 0);
		send_op(F_INS_BEFORE, 128, 0);
		send_op(F_INS_AFTER, 255, 0);        // already held
		send_op(F_INS_AFTER, 3, 77);         // absent anchor
		send_op(F_PREV, 0);
		send_op(F_NEXT, 255);
		send_op(F_SPARE_A, 1);
		send_op(F_SPARE_B, 2);
		send_op(F_REMOVE, 0);                // slot 0 hole filled
		send_op(F_FIRST, 0);
		send_op(F_REMOVE, 255);
		send_op(F_NEXT, 128);                // one left, self linked
		send_op(F_REMOVE, 128);              // ring empties
		send_op(F_FIRST, 0);
	endtask

	// fill to capacity then hit the full store
	task automatic test_full();
		send_op(F_INS_BEFORE, 100, 0, 1);
		for (int i = 0; ring_count < SLOTS; i++)
			send_op(i[0] ? F_INS_AFTER : F_INS_BEFORE, $urandom_range(255), pick_held());
		send_op(F_INS_AFTER, 42, 77);        // anchor test before full test
		send_op(F_INS_AFTER, ring_held[1] ? 2 : 1, pick_held());
		send_op(F_FIRST, 0);
		while (ring_count > 0) send_op(F_REMOVE, pick_held());
	endtask

	// mostly well-formed operations on held values, some noise
	task automatic test_random(int n);
		int r, v, a;
		logic [FUNC_W-1:0] f;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			v = $urandom_range(255);
			a = (r < 85) ? pick_held() : $urandom_range(255);
			if (ring_count == 0 && r < 80) begin
				send_op(F_INS_AFTER, v, a, 1);
				continue;
			end
			// bias growth or shrink so fill level wanders end to end
			if (r < 40 && ring_count < 60) f = r[0] ? F_INS_AFTER : F_INS_BEFORE;
			else if (r < 55) f = F_REMOVE;
			else f = FUNC_W'($urandom_range(7));
			if ((f == F_REMOVE || f == F_NEXT || f == F_PREV) && r < 90) v = pick_held();
			send_op(f, v, a, $urandom_range(19) == 0);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_idle_pct = 0; recv_stall_pct = 0;
		test_directed();
		test_full();
		test_random(350);
		drain();    // sender holds off until every result is back

		send_idle_pct = 76; recv_stall_pct = 0;
		test_random(350);
		send_idle_pct = 0; recv_stall_pct = 76;
		test_random(350);
		send_idle_pct = 15; recv_stall_pct = 15;
		test_random(350);
		test_full();

		drain();
		recv_stall_pct = 0;
		repeat (40) @(posedge clk);
		$display("sent %0d transactions, checked %0d results (ok %0d, nonempty %0d, full %0d, absent %0d)",
			items_sent, results_seen, cnt_by_status[S_OK], cnt_by_status[S_NONEMPTY],
			cnt_by_status[S_FULL], cnt_by_status[S_ABSENT]);
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
